>>> hdl/ostm_pkg.sv
`default_nettype none
package ostm_pkg;
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_NONE = 2'd2,
    ST_OVF  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SQ,
    S_VAR,
    S_KEEP,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic clr;
    logic store;
    logic start_sq;
    logic step_sq;
    logic calc_var;
    logic start_keep;
    logic step_keep;
    logic start_div;
    logic step_div;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic scan_done;
    logic div_done;
    logic none_kept;
  } sts_t;
endpackage
`default_nettype wire

>>> hdl/ostm_ctrl.sv
`default_nettype none
module ostm_ctrl
  import ostm_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  input  wire  logic last_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire  logic out_stall_i,
  input  wire  sts_t sts_i,
  output cmd_t       cmd_o
);
  state_e state_q, state_d;
  logic acc;

  assign acc = in_valid_i && (state_q == S_LOAD);
  assign in_stall_o = (state_q != S_LOAD);
  assign out_valid_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (acc && last_i) state_d = S_SQ;
      end
      S_SQ: begin
        if (sts_i.few) state_d = S_OUT;
        else if (sts_i.scan_done) state_d = S_VAR;
      end
      S_VAR: state_d = S_KEEP;
      S_KEEP: begin
        if (sts_i.scan_done) state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.none_kept || sts_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.store = acc;
        cmd_o.start_sq = acc && last_i;
      end
      S_SQ: cmd_o.step_sq = 1'b1;
      S_VAR: begin
        cmd_o.calc_var = 1'b1;
        cmd_o.start_keep = 1'b1;
      end
      S_KEEP: begin
        cmd_o.step_keep = 1'b1;
        cmd_o.start_div = sts_i.scan_done;
      end
      S_DIV: cmd_o.step_div = 1'b1;
      S_OUT: cmd_o.clr = !out_stall_i;
      default: cmd_o = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/ostm_dp.sv
`default_nettype none
module ostm_dp
  import ostm_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic [15:0] sample_i,
  input  wire  cmd_t        cmd_i,
  output sts_t              sts_o,
  output logic [23:0]       mean_value_o,
  output logic [1:0]        status_o
);
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SB = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int SW = SB + CW;
  localparam int QW = 2 * SB + CW;
  localparam int NDW = SB + CW;
  localparam int VW = QW + CW + 1;
  localparam int DVW = 2 * NDW;
  localparam int TW = SW + 8;

  logic [SB-1:0] mem [MAX_SAMPLES];
  logic [SB-1:0] rd_q;
  logic [CW-1:0] cnt_q, idx_q;
  logic          rd_vld_q;
  logic [SW-1:0] sum_q;
  logic          ovf_q;
  logic [QW-1:0] q_q;
  logic [VW-1:0] var_q;
  logic [SW-1:0] ksum_q;
  logic [CW-1:0] kn_q;
  logic [NDW-1:0] nd_q, dev_w;
  logic [SB-1:0] sd_q;
  logic          nd_vld_q;
  logic [TW-1:0] rem_q, quo_q;
  logic [TW:0]   trial;
  logic [$clog2(TW+1)-1:0] dcnt_q;
  logic [23:0]   mean_q;
  logic [1:0]    st_q;
  logic [SB-1:0] d;
  logic [2*SB-1:0] sq_w;
  logic          scanning;

  assign d = sample_i[SB-1:0];
  assign scanning = cmd_i.step_sq || cmd_i.step_keep;
  assign sq_w = rd_q * rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && (cnt_q < CW'(MAX_SAMPLES))) mem[cnt_q[AW-1:0]] <= d;
    rd_q <= mem[idx_q[AW-1:0]];
  end

  assign dev_w = (nd_q >= NDW'(sum_q)) ? nd_q - NDW'(sum_q) : NDW'(sum_q) - nd_q;
  assign trial = {rem_q, quo_q[TW-1]} - {1'b0, (TW)'(kn_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sum_q <= '0; ovf_q <= 1'b0; idx_q <= '0; rd_vld_q <= 1'b0;
      q_q <= '0; var_q <= '0; ksum_q <= '0; kn_q <= '0; nd_q <= '0; sd_q <= '0;
      nd_vld_q <= 1'b0; rem_q <= '0; quo_q <= '0; dcnt_q <= '0;
      mean_q <= '0; st_q <= ST_OK;
    end else begin
      if (cmd_i.clr) begin
        cnt_q <= '0; sum_q <= '0; ovf_q <= 1'b0;
      end else if (cmd_i.store) begin
        if (cnt_q < CW'(MAX_SAMPLES)) begin
          cnt_q <= cnt_q + 1'b1;
          sum_q <= sum_q + SW'(d);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.start_sq || cmd_i.start_keep) begin
        idx_q <= '0; rd_vld_q <= 1'b0; nd_vld_q <= 1'b0;
        if (cmd_i.start_sq) q_q <= '0;
        if (cmd_i.start_keep) begin ksum_q <= '0; kn_q <= '0; end
      end else if (scanning) begin
        rd_vld_q <= (idx_q < cnt_q);
        if (idx_q < cnt_q) idx_q <= idx_q + 1'b1;
        if (cmd_i.step_sq && rd_vld_q) q_q <= q_q + QW'(sq_w);
        if (cmd_i.step_keep) begin
          nd_vld_q <= rd_vld_q;
          nd_q <= NDW'(rd_q) * NDW'(cnt_q);
          sd_q <= rd_q;
          if (nd_vld_q && (DVW'(dev_w) * DVW'(dev_w) <= DVW'(var_q))) begin
            ksum_q <= ksum_q + SW'(sd_q);
            kn_q <= kn_q + 1'b1;
          end
        end
      end
      if (cmd_i.calc_var) var_q <= VW'(q_q) * VW'(cnt_q) - VW'(sum_q) * VW'(sum_q);
      if (cmd_i.start_div) begin
        rem_q <= '0; quo_q <= {ksum_q, 8'd0}; dcnt_q <= '0;
      end else if (cmd_i.step_div && dcnt_q < ($clog2(TW+1))'(TW)) begin
        dcnt_q <= dcnt_q + 1'b1;
        if (!trial[TW]) begin
          rem_q <= trial[TW-1:0]; quo_q <= {quo_q[TW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[TW-2:0], quo_q[TW-1]}; quo_q <= {quo_q[TW-2:0], 1'b0};
        end
      end
      if (cmd_i.step_sq && (cnt_q < CW'(2))) begin
        mean_q <= '0; st_q <= ST_FEW;
      end else if (cmd_i.step_div && kn_q == '0) begin
        mean_q <= '0; st_q <= ST_NONE;
      end else if (cmd_i.step_div && dcnt_q == ($clog2(TW+1))'(TW)) begin
        mean_q <= (quo_q > TW'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(quo_q);
        st_q <= ovf_q ? ST_OVF : ST_OK;
      end
    end
  end

  assign sts_o.few = (cnt_q < CW'(2));
  assign sts_o.scan_done = (idx_q == cnt_q) && !rd_vld_q && !nd_vld_q && scanning;
  assign sts_o.div_done = cmd_i.step_div && dcnt_q == ($clog2(TW+1))'(TW);
  assign sts_o.none_kept = (kn_q == '0);
  assign mean_value_o = mean_q;
  assign status_o = st_q;
endmodule
`default_nettype wire

>>> hdl/one_sigma_truncated_mean.sv
`default_nettype none
// The result follows the closing word once the passes and the divide below are done;
// with under two samples it is given without them.
// Throughput: one sample word per cycle while loading; the set then runs two
// passes over the sample RAM (one read per cycle) and a 35-step bit-serial divider.
// Reset (asynchronous, active low) empties the set; the RAM is not cleared.
module one_sigma_truncated_mean
  import ostm_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        in_valid_i,
  output logic              in_stall_o,
  input  wire  logic [15:0] sample_i,
  input  wire  logic        last_i,
  output logic              out_valid_o,
  input  wire  logic        out_stall_i,
  output logic [23:0]       mean_value_o,
  output logic [1:0]        status_o
);
  cmd_t cmd;
  sts_t sts;

  ostm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .last_i, .in_stall_o,
    .out_valid_o, .out_stall_i, .sts_i(sts), .cmd_o(cmd)
  );

  ostm_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk_i, .rst_ni, .sample_i, .cmd_i(cmd), .sts_o(sts),
    .mean_value_o, .status_o
  );
endmodule
`default_nettype wire

>>> tb/sv/tb_one_sigma_truncated_mean.sv
`timescale 1ns / 100ps
module tb_one_sigma_truncated_mean;
  import ostm_pkg::*;

  localparam int CAPACITY = 1024;

  typedef struct {
    logic [23:0] mean_value;
    status_e     status;
  } tmean_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] sample_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [23:0] mean_value_o;
  logic [1:0]  status_o;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;
  int          mismatches = 0;

  logic [15:0] set_q[$];
  bit          dropped;
  tmean_t      tmean_q[$];

  one_sigma_truncated_mean i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mean_value_o(mean_value_o),
    .status_o    (status_o)
  );

  always #5 clk_i = ~clk_i;

  // exact one-sigma test, scaled by n^2
  function automatic tmean_t trunc_mean();
    tmean_t       r;
    logic [127:0] n, s, q, var_n, nd, dev, kept_sum, kept_n, m;
    n = set_q.size();
    s = '0;
    q = '0;
    kept_sum = '0;
    kept_n = '0;
    r.mean_value = '0;
    if (n < 2) begin
      r.status = ST_FEW;
      return r;
    end
    foreach (set_q[i]) begin
      s += set_q[i];
      q += set_q[i] * set_q[i];
    end
    var_n = n * q - s * s;
    foreach (set_q[i]) begin
      nd = n * set_q[i];
      dev = (nd >= s) ? nd - s : s - nd;
      if (dev * dev <= var_n) begin
        kept_sum += set_q[i];
        kept_n += 1;
      end
    end
    if (kept_n == 0) begin
      r.status = ST_NONE;
    end else begin
      m = (kept_sum << 8) / kept_n;
      r.mean_value = (m > 128'hFFFFFF) ? 24'hFFFFFF : m[23:0];
      r.status = dropped ? ST_OVF : ST_OK;
    end
    return r;
  endfunction

  task automatic send_sample(input logic [15:0] d, input bit lst);
    int gap;
    in_valid_i <= 1'b1;
    sample_i <= d;
    last_i <= lst;
    do @(posedge clk_i); while (in_stall_o);
    if (set_q.size() < CAPACITY) set_q = {set_q, d};
    else dropped = 1'b1;
    if (lst) begin
      tmean_q = {tmean_q, trunc_mean()};
      set_q.delete();
      dropped = 1'b0;
    end
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_set(input int len, input int style);
    logic [15:0] base;
    logic [15:0] d;
    base = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: d = $urandom_range(0, 65535);
        1: d = base ^ 16'($urandom_range(0, 255));
        default: d = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535)) : base;
      endcase
      send_sample(d, i == len - 1);
    end
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_sample(16'd5, 1'b1);
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    repeat (3) send_sample(16'd7, 1'b0);
    send_sample(16'd7, 1'b1);
    repeat (3) send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    repeat (2) send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'd1, 1'b0);
    send_sample(16'd2, 1'b0);
    send_sample(16'd3, 1'b0);
    send_sample(16'd4, 1'b0);
    send_sample(16'd100, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
  endtask

  task automatic test_overflow();
    idle_pct = 0;
    stall_pct = 50;
    // full store, closing word dropped
    for (int i = 0; i < CAPACITY; i++) send_sample(16'($urandom_range(0, 65535)), 1'b0);
    send_sample(16'hFFFF, 1'b1);
  endtask

  task automatic test_random(input int items, input int idle, input int stall);
    int cnt;
    int len;
    idle_pct = idle;
    stall_pct = stall;
    cnt = 0;
    while (cnt < items) begin
      case ($urandom_range(0, 19))
        0: len = 1;
        1: len = $urandom_range(60, 200);
        default: len = $urandom_range(2, 16);
      endcase
      send_set(len, $urandom_range(0, 2));
      cnt += len;
    end
  endtask

  always @(posedge clk_i) begin
    tmean_t e;
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tmean_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: mean %0d status %0d",
                                       mean_value_o, status_o);
      end else begin
        e = tmean_q.pop_front();
        if (mean_value_o !== e.mean_value || status_o !== e.status) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: mean exp %0d got %0d, status exp %0d got %0d",
                     e.mean_value, mean_value_o, e.status, status_o);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int waited;
    dropped = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(100, 0, 0);
    test_random(100, 84, 0);
    test_random(100, 0, 84);
    test_random(100, 28, 28);
    in_valid_i <= 1'b0;
    waited = 0;
    while (tmean_q.size() > 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    if (tmean_q.size() > 0) errors++;
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> files.f
hdl/ostm_pkg.sv
hdl/ostm_ctrl.sv
hdl/ostm_dp.sv
hdl/one_sigma_truncated_mean.sv
tb/sv/tb_one_sigma_truncated_mean.sv
